/* sv/vcc_pkg.sv */
// vcc_pkg: shared types, constants and arithmetic helpers for vertex centroid centering
`timescale 1ns / 1ps

package vcc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS   = 32;
  localparam int INDEX_W      = 10;
  localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W        = COORD_BITS + ADDR_W;
  localparam int STEP_W       = $clog2(SUM_W);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [SUM_W-1:0]             mag_t;
  typedef mag_t [2:0]                   mag3_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [INDEX_W-1:0]           index_t;

  localparam cnt_t CNT_MAX = CNT_W'(MAX_VERTICES);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SHIFT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_CENTROID = 2'd0,
    KIND_VERTEX   = 2'd1,
    KIND_SHIFT    = 2'd2
  } kind_t;

  function automatic coord_t sat_sub(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] d;
    coord_t res;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS] != d[COORD_BITS-1]) begin
      res = d[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      res = d[COORD_BITS-1:0];
    end
    return res;
  endfunction

  function automatic mag_t abs_sum(sum_t s);
    mag_t m;
    m = s[SUM_W-1] ? mag_t'(-s) : mag_t'(s);
    return m;
  endfunction

  function automatic coord_t apply_sign(mag_t q, logic neg);
    mag_t qs;
    qs = neg ? (~q + mag_t'(1)) : q;
    return qs[COORD_BITS-1:0];
  endfunction

endpackage

/* sv/vcc_div.sv */
// vcc_div: three-lane restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module vcc_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  vcc_pkg::mag3_t dividend,
  input  vcc_pkg::cnt_t  divisor,
  output logic          done,
  output vcc_pkg::mag3_t quotient
);
  import vcc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  cnt_t              div_r;
  mag3_t             dq_r;
  cnt_t              rem_r   [3];
  mag3_t             dq_nxt;
  cnt_t              rem_nxt [3];
  logic [CNT_W:0]    rem_sh  [3];
  logic [CNT_W:0]    diff    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i]  = {rem_r[i], dq_r[i][SUM_W-1]};
      diff[i]    = rem_sh[i] - {1'b0, div_r};
      rem_nxt[i] = diff[i][CNT_W] ? rem_sh[i][CNT_W-1:0] : diff[i][CNT_W-1:0];
      dq_nxt[i]  = {dq_r[i][SUM_W-2:0], ~diff[i][CNT_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      dq_r  <= dividend;
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= '0;
      end
    end else if (busy_r) begin
      dq_r <= dq_nxt;
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

/* sv/vertex_centroid_centering.sv */
// vertex_centroid_centering: vertex store, running sums, centroid and centering datapath
// load: one request per cycle while idle, no result; shift: result registered in the cycle after accept
// read: result passes the registered vertex memory read port, then the output register
// finish: waits on the 42-step bit-serial divider; an empty mesh skips the divider
// one request at a time for read and finish, not for shift; output register frees the input side
// reset (sync, active low) clears sums, count, centroid and flags; vertex memory is not cleared
`timescale 1ns / 1ps

module vertex_centroid_centering (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  vcc_pkg::coord_t  in_coord_x,
  input  vcc_pkg::coord_t  in_coord_y,
  input  vcc_pkg::coord_t  in_coord_z,
  input  vcc_pkg::index_t  in_vertex_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output vcc_pkg::coord_t  out_x,
  output vcc_pkg::coord_t  out_y,
  output vcc_pkg::coord_t  out_z,
  output vcc_pkg::cnt_t    out_loaded_count,
  output logic             out_dropped_flag,
  output logic             out_index_error
);
  import vcc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t  state_r, state_nxt;
  cnt_t    cnt_r;
  sum_t    sum_x_r, sum_y_r, sum_z_r;
  coord_t  cent_x_r, cent_y_r, cent_z_r;
  logic    ovf_r;
  logic    fin_r;
  logic    neg_x_r, neg_y_r, neg_z_r;
  vertex_t rd_data_r;
  logic    rd_err_r;

  vertex_t vtx_mem [MAX_VERTICES];

  logic    out_valid_r;
  kind_t   out_kind_r;
  coord_t  out_x_r, out_y_r, out_z_r;
  cnt_t    out_cnt_r;
  logic    out_drop_r;
  logic    out_err_r;

  logic    in_acc;
  logic    out_free;
  logic    is_load, is_finish, is_read, is_shift;
  logic    wr_en;
  addr_t   wr_addr;
  vertex_t wr_data;
  logic    rd_en;
  addr_t   rd_addr;
  logic    div_start;
  logic    div_done;
  mag3_t   div_dividend;
  mag3_t   div_quot;

  logic    res_ld;
  kind_t   res_kind;
  coord_t  res_x, res_y, res_z;
  logic    res_err;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || ((in_cmd == CMD_SHIFT) && !out_free);
  assign in_acc    = in_valid && !in_stall;
  assign is_load   = in_acc && (in_cmd == CMD_LOAD);
  assign is_finish = in_acc && (in_cmd == CMD_FINISH);
  assign is_read   = in_acc && (in_cmd == CMD_READ);
  assign is_shift  = in_acc && (in_cmd == CMD_SHIFT);

  // vertex store
  assign wr_en   = is_load && (fin_r || (cnt_r != CNT_MAX));
  assign wr_addr = fin_r ? '0 : cnt_r[ADDR_W-1:0];
  assign wr_data = '{x: in_coord_x, y: in_coord_y, z: in_coord_z};
  assign rd_en   = is_read;
  assign rd_addr = ADDR_W'(in_vertex_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vtx_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= vtx_mem[rd_addr];
      rd_err_r  <= CNT_W'(in_vertex_index) >= cnt_r;
    end
  end

  // centroid divider
  assign div_start    = is_finish && (cnt_r != '0);
  assign div_dividend = {abs_sum(sum_z_r), abs_sum(sum_y_r), abs_sum(sum_x_r)};

  vcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_x_r <= sum_x_r[SUM_W-1];
      neg_y_r <= sum_y_r[SUM_W-1];
      neg_z_r <= sum_z_r[SUM_W-1];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (is_read) begin
          state_nxt = S_READ;
        end else if (is_finish) begin
          state_nxt = (cnt_r == '0) ? S_FIN : S_DIV;
        end
      end
      S_READ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // mesh state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_z_r  <= '0;
      cent_x_r <= '0;
      cent_y_r <= '0;
      cent_z_r <= '0;
      ovf_r    <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (is_load) begin
        if (fin_r) begin
          sum_x_r <= SUM_W'(in_coord_x);
          sum_y_r <= SUM_W'(in_coord_y);
          sum_z_r <= SUM_W'(in_coord_z);
          cnt_r   <= CNT_W'(1);
          ovf_r   <= 1'b0;
          fin_r   <= 1'b0;
        end else if (cnt_r == CNT_MAX) begin
          ovf_r <= 1'b1;
        end else begin
          sum_x_r <= sum_x_r + SUM_W'(in_coord_x);
          sum_y_r <= sum_y_r + SUM_W'(in_coord_y);
          sum_z_r <= sum_z_r + SUM_W'(in_coord_z);
          cnt_r   <= cnt_r + CNT_W'(1);
        end
      end
      if (is_finish) begin
        fin_r <= 1'b1;
        if (cnt_r == '0) begin
          cent_x_r <= '0;
          cent_y_r <= '0;
          cent_z_r <= '0;
        end
      end
      if (div_done) begin
        cent_x_r <= apply_sign(div_quot[0], neg_x_r);
        cent_y_r <= apply_sign(div_quot[1], neg_y_r);
        cent_z_r <= apply_sign(div_quot[2], neg_z_r);
      end
    end
  end

  // result select
  always_comb begin
    res_ld   = 1'b0;
    res_kind = KIND_SHIFT;
    res_x    = sat_sub(in_coord_x, cent_x_r);
    res_y    = sat_sub(in_coord_y, cent_y_r);
    res_z    = sat_sub(in_coord_z, cent_z_r);
    res_err  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        res_ld = is_shift;
      end
      S_READ: begin
        res_ld   = out_free;
        res_kind = KIND_VERTEX;
        res_err  = rd_err_r;
        if (rd_err_r) begin
          res_x = '0;
          res_y = '0;
          res_z = '0;
        end else begin
          res_x = sat_sub(rd_data_r.x, cent_x_r);
          res_y = sat_sub(rd_data_r.y, cent_y_r);
          res_z = sat_sub(rd_data_r.z, cent_z_r);
        end
      end
      S_DIV: begin
        res_ld = 1'b0;
      end
      S_FIN: begin
        res_ld   = out_free;
        res_kind = KIND_CENTROID;
        res_x    = cent_x_r;
        res_y    = cent_y_r;
        res_z    = cent_z_r;
      end
      default: res_ld = 1'b0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) begin
      out_kind_r <= res_kind;
      out_x_r    <= res_x;
      out_y_r    <= res_y;
      out_z_r    <= res_z;
      out_cnt_r  <= cnt_r;
      out_drop_r <= ovf_r;
      out_err_r  <= res_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_z            = out_z_r;
  assign out_loaded_count = out_cnt_r;
  assign out_dropped_flag = out_drop_r;
  assign out_index_error  = out_err_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("stored count beyond capacity");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  a_fin_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> fin_r)
    else $error("centroid emitted without finish flag");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |->
      (out_kind_r == KIND_VERTEX) && (out_x_r == '0) && (out_y_r == '0) && (out_z_r == '0))
    else $error("index error on a result that is not a zeroed vertex read");

endmodule

/* test/tb_vertex_centroid_centering.sv */
// tb_vertex_centroid_centering: self-checking testbench with a centroid centering predictor
`timescale 1ns / 1ps

module tb_vertex_centroid_centering;
  import vcc_pkg::*;

  localparam coord_t      C_MAX        = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t      C_MIN        = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned IDLE_PCT     = 18;

  typedef struct {
    kind_t  kind;
    coord_t x;
    coord_t y;
    coord_t z;
    cnt_t   count;
    logic   dropped;
    logic   idx_err;
  } centered_result_t;

  class mesh_centering;
    coord_t           vert_x[MAX_VERTICES];
    coord_t           vert_y[MAX_VERTICES];
    coord_t           vert_z[MAX_VERTICES];
    longint           total_x, total_y, total_z;
    int unsigned      count;
    coord_t           cen_x, cen_y, cen_z;
    bit               overflow;
    bit               mesh_done;
    centered_result_t due_results[$];
    int unsigned      errors, checked, saturations, bad_reads, largest;
    int unsigned      per_cmd[4];

    function new();
      total_x = 0;
      total_y = 0;
      total_z = 0;
      count = 0;
      cen_x = '0;
      cen_y = '0;
      cen_z = '0;
      overflow = 1'b0;
      mesh_done = 1'b0;
    endfunction

    function coord_t clamp_diff(coord_t a, coord_t b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d > longint'(C_MAX)) begin
        d = longint'(C_MAX);
        saturations++;
      end else if (d < longint'(C_MIN)) begin
        d = longint'(C_MIN);
        saturations++;
      end
      return coord_t'(d);
    endfunction

    // integer division truncates toward zero
    function coord_t mean_of(longint s);
      if (count == 0) return '0;
      return coord_t'(s / longint'(count));
    endfunction

    function void take_request(cmd_t c, coord_t x, coord_t y, coord_t z, index_t idx);
      centered_result_t r;
      per_cmd[c]++;
      if (c == CMD_LOAD) begin
        if (mesh_done) begin
          total_x = 0;
          total_y = 0;
          total_z = 0;
          count = 0;
          overflow = 1'b0;
          mesh_done = 1'b0;
        end
        if (count >= MAX_VERTICES) begin
          overflow = 1'b1;
        end else begin
          vert_x[count] = x;
          vert_y[count] = y;
          vert_z[count] = z;
          total_x += longint'(x);
          total_y += longint'(y);
          total_z += longint'(z);
          count++;
          if (count > largest) largest = count;
        end
      end else begin
        r.count = cnt_t'(count);
        r.dropped = overflow;
        r.idx_err = 1'b0;
        case (c)
          CMD_FINISH: begin
            cen_x = mean_of(total_x);
            cen_y = mean_of(total_y);
            cen_z = mean_of(total_z);
            mesh_done = 1'b1;
            r.kind = KIND_CENTROID;
            r.x = cen_x;
            r.y = cen_y;
            r.z = cen_z;
          end
          CMD_READ: begin
            r.kind = KIND_VERTEX;
            if (idx < count) begin
              r.x = clamp_diff(vert_x[idx], cen_x);
              r.y = clamp_diff(vert_y[idx], cen_y);
              r.z = clamp_diff(vert_z[idx], cen_z);
            end else begin
              r.x = '0;
              r.y = '0;
              r.z = '0;
              r.idx_err = 1'b1;
              bad_reads++;
            end
          end
          default: begin
            r.kind = KIND_SHIFT;
            r.x = clamp_diff(x, cen_x);
            r.y = clamp_diff(y, cen_y);
            r.z = clamp_diff(z, cen_z);
          end
        endcase
        due_results.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [COORD_BITS-1:0] want,
                                logic [COORD_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [1:0] kind, coord_t x, coord_t y, coord_t z,
                               cnt_t cnt, logic dropped, logic idx_err);
      centered_result_t e;
      if (due_results.size() == 0) begin
        $error("result of kind %0d with no request outstanding", kind);
        errors++;
      end else begin
        e = due_results.pop_front();
        checked++;
        compare_field("out_kind", e.kind, kind);
        compare_field("out_x", e.x, x);
        compare_field("out_y", e.y, y);
        compare_field("out_z", e.z, z);
        compare_field("out_loaded_count", e.count, cnt);
        compare_field("out_dropped_flag", e.dropped, dropped);
        compare_field("out_index_error", e.idx_err, idx_err);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_LOAD;
  coord_t      in_coord_x = '0;
  coord_t      in_coord_y = '0;
  coord_t      in_coord_z = '0;
  index_t      in_vertex_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  coord_t      out_x;
  coord_t      out_y;
  coord_t      out_z;
  cnt_t        out_loaded_count;
  logic        out_dropped_flag;
  logic        out_index_error;

  bit            idling_enabled = 1'b1;
  int unsigned   requests_sent = 0;
  mesh_centering mesh = new();

  vertex_centroid_centering dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_vertex_index  (in_vertex_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .out_loaded_count (out_loaded_count),
    .out_dropped_flag (out_dropped_flag),
    .out_index_error  (out_index_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coord_t any_coord();
    case ($urandom_range(9))
      0: return C_MAX;
      1: return C_MIN;
      2: return coord_t'(int'($urandom_range(8191)) - 4096);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // mostly indexes that hit the current mesh, sometimes anything
  function automatic index_t pick_index();
    if (mesh.count != 0 && $urandom_range(7) != 0) return index_t'($urandom_range(mesh.count - 1));
    return index_t'($urandom);
  endfunction

  task automatic issue(cmd_t c, coord_t x, coord_t y, coord_t z, index_t idx);
    while (idling_enabled && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_vertex_index <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    mesh.take_request(c, x, y, z, idx);
    requests_sent++;
  endtask

  task automatic command(cmd_t c, index_t idx);
    issue(c, any_coord(), any_coord(), any_coord(), idx);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (mesh.due_results.size() != 0);
  endtask

  task automatic random_mesh();
    int unsigned loads;
    loads = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
    for (int unsigned i = 0; i < loads; i++) begin
      if ($urandom_range(11) == 0) command($urandom_range(1) ? CMD_SHIFT : CMD_READ, pick_index());
      command(CMD_LOAD, index_t'($urandom));
    end
    command(CMD_FINISH, index_t'($urandom));
    if ($urandom_range(6) == 0) command(CMD_FINISH, index_t'($urandom));
    repeat ($urandom_range(1, 8)) command($urandom_range(3) == 0 ? CMD_SHIFT : CMD_READ, pick_index());
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      issue(cmd_t'($urandom_range(3)), any_coord(), any_coord(), any_coord(), index_t'($urandom));
  endtask

  // fill the store, overrun it, then finish and read across the whole range
  task automatic full_mesh();
    wait_for_results();
    command(CMD_FINISH, '0);
    for (int i = 0; i < MAX_VERTICES + 3; i++) begin
      // long stretch of the fill with no idling
      idling_enabled = !(i >= 300 && i < 600);
      command(CMD_LOAD, index_t'($urandom));
    end
    idling_enabled = 1'b1;
    command(CMD_READ, index_t'(MAX_VERTICES - 1));
    command(CMD_FINISH, '0);
    command(CMD_READ, index_t'(MAX_VERTICES - 1));
    command(CMD_READ, '0);
    repeat (12) command(CMD_READ, index_t'($urandom));
    command(CMD_SHIFT, '0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        mesh.match_result(out_kind, out_x, out_y, out_z, out_loaded_count,
                          out_dropped_flag, out_index_error);
      out_stall <= idling_enabled && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("** vertex_centroid_centering: FAILED **");
    $finish;
  end

  initial begin
    int unsigned meshes;
    meshes = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty mesh, bad read and shift with a zero centroid
    issue(CMD_FINISH, '0, '0, '0, '0);
    issue(CMD_READ, '0, '0, '0, '0);
    issue(CMD_SHIFT, C_MIN, C_MAX, '0, '0);
    // extreme coordinates, negative sum truncated toward zero
    issue(CMD_LOAD, C_MAX, C_MIN, -7, '0);
    issue(CMD_LOAD, C_MAX, C_MIN, '0, 10'h3ff);
    issue(CMD_LOAD, C_MAX, C_MIN, '0, '0);
    issue(CMD_FINISH, '0, '0, '0, '0);
    issue(CMD_FINISH, C_MAX, C_MAX, C_MAX, '0);
    for (int i = 0; i < 4; i++) issue(CMD_READ, '0, '0, '0, index_t'(i));
    issue(CMD_READ, '0, '0, '0, 10'h3ff);
    issue(CMD_SHIFT, C_MIN, C_MAX, C_MIN, '0);
    issue(CMD_SHIFT, '0, '0, '0, '0);
    // new mesh, read before its finish uses the old centroid
    issue(CMD_LOAD, C_MIN, C_MAX, 32'sh0001_8000, '0);
    issue(CMD_READ, '0, '0, '0, '0);
    issue(CMD_LOAD, -1, 1, -32'sh0001_8000, '0);
    issue(CMD_FINISH, '0, '0, '0, '0);
    issue(CMD_READ, '0, '0, '0, 10'd1);
    issue(CMD_SHIFT, C_MAX, C_MIN, '0, '0);
    wait_for_results();

    while (requests_sent < RANDOM_ITEMS) begin
      meshes++;
      if ($urandom_range(99) < 85) random_mesh();
      else noise_burst();
      if (meshes % 10 == 0) wait_for_results();
      if (meshes == 2) full_mesh();
    end
    idling_enabled = 1'b1;
    wait_for_results();
    repeat (60) @(posedge clk);

    $display("covered %0d loads (largest mesh %0d), %0d finishes, %0d reads, %0d shifts",
             mesh.per_cmd[CMD_LOAD], mesh.largest, mesh.per_cmd[CMD_FINISH],
             mesh.per_cmd[CMD_READ], mesh.per_cmd[CMD_SHIFT]);
    $display("%0d results checked, %0d bad-index reads, %0d saturated coordinates",
             mesh.checked, mesh.bad_reads, mesh.saturations);
    if (mesh.errors == 0) begin
      $display("** vertex_centroid_centering: PASSED **");
    end else begin
      $display("** vertex_centroid_centering: FAILED **");
    end
    $finish;
  end

endmodule
